// ----- design/stcs_pkg.sv -----
// shared types and constants for the step test capture sequencer
// no dependencies; imported by every module of the block

package stcs_pkg;

  // register file geometry: six 32-bit registers at byte address 4*i
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_DECIMATION       = 3'd0;
  localparam logic [2:0] REG_MAX_SAMPLES      = 3'd1;
  localparam logic [2:0] REG_TIMEOUT_MS       = 3'd2;
  localparam logic [2:0] REG_SETTLE_DELAY_MS  = 3'd3;
  localparam logic [2:0] REG_SETTLE_THRESHOLD = 3'd4;
  localparam logic [2:0] REG_SETTLE_NEEDED    = 3'd5;

  localparam logic [15:0] DECIMATION_RST       = 16'd20;
  localparam logic [15:0] MAX_SAMPLES_RST      = 16'd4000;
  localparam logic [19:0] TIMEOUT_MS_RST       = 20'd12000;
  localparam logic [19:0] SETTLE_DELAY_MS_RST  = 20'd500;
  localparam logic [14:0] SETTLE_THRESHOLD_RST = 15'd192;
  localparam logic [7:0]  SETTLE_NEEDED_RST    = 8'd5;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [7:0] QUIET_MAX = 8'd255;

  typedef enum logic [1:0] {
    STOP_SETTLED     = 2'd0,
    STOP_BUFFER_FULL = 2'd1,
    STOP_TIMEOUT     = 2'd2,
    STOP_ABORTED     = 2'd3
  } end_cause_t;

  typedef struct packed {
    logic [15:0] decimation;
    logic [15:0] max_samples;
    logic [19:0] timeout_ms;
    logic [19:0] settle_delay_ms;
    logic [14:0] settle_threshold;
    logic [7:0]  settle_needed;
  } cfg_t;

  typedef struct packed {
    logic               command;
    logic [31:0]        now_ms;
    logic signed [14:0] from_mv;
    logic signed [14:0] to_mv;
    logic [19:0]        hold_ms;
    logic signed [15:0] rate_sample;
    logic               abort_request;
  } item_t;

  typedef struct packed {
    logic signed [14:0] drive_mv;
    logic               log_strobe;
    logic [15:0]        sample_index;
    logic               in_phase_b;
    logic               capture_done;
    end_cause_t         end_cause;
  } result_t;

endpackage

// ----- design/stcs_item_if.sv -----
// input channel of the step test capture sequencer
// valid/ready handshake with the start and tick item fields

interface stcs_item_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [31:0]        now_ms;
  logic signed [14:0] from_mv;
  logic signed [14:0] to_mv;
  logic [19:0]        hold_ms;
  logic signed [15:0] rate_sample;
  logic               abort_request;

  modport source (
    output valid, command, now_ms, from_mv, to_mv, hold_ms, rate_sample, abort_request,
    input  ready
  );
  modport sink (
    input  valid, command, now_ms, from_mv, to_mv, hold_ms, rate_sample, abort_request,
    output ready
  );
endinterface

// ----- design/stcs_result_if.sv -----
// result channel of the step test capture sequencer
// valid/ready handshake with the drive and capture status fields

interface stcs_result_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] drive_mv;
  logic               log_strobe;
  logic [15:0]        sample_index;
  logic               in_phase_b;
  logic               capture_done;
  logic [1:0]         end_cause;

  modport source (
    output valid, drive_mv, log_strobe, sample_index, in_phase_b, capture_done, end_cause,
    input  ready
  );
  modport sink (
    input  valid, drive_mv, log_strobe, sample_index, in_phase_b, capture_done, end_cause,
    output ready
  );
endinterface

// ----- design/stcs_cfg_regs.sv -----
// apb-style configuration registers of the step test capture sequencer
// depends on stcs_pkg for register indexes, reset values and cfg_t

module stcs_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stcs_pkg::ADDR_W-1:0]   paddr,
  input  logic [stcs_pkg::DATA_W-1:0]   pwdata,
  output logic [stcs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output stcs_pkg::cfg_t                cfg
);
  import stcs_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decimation       <= DECIMATION_RST;
      cfg.max_samples      <= MAX_SAMPLES_RST;
      cfg.timeout_ms       <= TIMEOUT_MS_RST;
      cfg.settle_delay_ms  <= SETTLE_DELAY_MS_RST;
      cfg.settle_threshold <= SETTLE_THRESHOLD_RST;
      cfg.settle_needed    <= SETTLE_NEEDED_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DECIMATION:       cfg.decimation       <= pwdata[15:0];
        REG_MAX_SAMPLES:      cfg.max_samples      <= pwdata[15:0];
        REG_TIMEOUT_MS:       cfg.timeout_ms       <= pwdata[19:0];
        REG_SETTLE_DELAY_MS:  cfg.settle_delay_ms  <= pwdata[19:0];
        REG_SETTLE_THRESHOLD: cfg.settle_threshold <= pwdata[14:0];
        REG_SETTLE_NEEDED:    cfg.settle_needed    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DECIMATION:       prdata = {16'd0, cfg.decimation};
      REG_MAX_SAMPLES:      prdata = {16'd0, cfg.max_samples};
      REG_TIMEOUT_MS:       prdata = {12'd0, cfg.timeout_ms};
      REG_SETTLE_DELAY_MS:  prdata = {12'd0, cfg.settle_delay_ms};
      REG_SETTLE_THRESHOLD: prdata = {17'd0, cfg.settle_threshold};
      REG_SETTLE_NEEDED:    prdata = {24'd0, cfg.settle_needed};
      default:              prdata = '0;
    endcase
  end

endmodule

// ----- design/stcs_engine.sv -----
// sequencer engine: input register, combinational step logic, result register
// depends on stcs_pkg for item_t, result_t, cfg_t and the codes

module stcs_engine (
  input  logic              clk,
  input  logic              rst,
  input  stcs_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  stcs_pkg::item_t   in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output stcs_pkg::result_t out_res
);
  import stcs_pkg::*;

  typedef struct packed {
    logic               running;
    logic               abort_latched;
    logic               phase_two;
    logic [31:0]        phase_one_start;
    logic [31:0]        phase_two_start;
    logic [19:0]        hold_time;
    logic signed [14:0] second_voltage;
    logic signed [14:0] drive_level;
    logic [15:0]        tick_count;
    logic [15:0]        stored_count;
    logic [7:0]         quiet_count;
  } state_t;

  logic    s1_valid;
  item_t   s1_item;
  logic    out_load;
  state_t  st;
  state_t  st_next;
  result_t res;

  // step scratch
  logic        abort_now;
  logic        done;
  logic        phase_out;
  logic        log_tick;
  logic [15:0] tick_inc;
  logic [31:0] hold_elapsed;
  logic [31:0] elapsed;
  logic [15:0] rate_mag;
  logic [7:0]  quiet_inc;

  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else if (out_load) begin
      st        <= st_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= res;
    end
  end

  always_comb begin
    st_next   = st;
    res       = '0;
    done      = 1'b0;
    phase_out = 1'b0;
    log_tick  = 1'b0;
    tick_inc  = 16'(st.tick_count + 16'd1);
    quiet_inc = (st.quiet_count < QUIET_MAX) ? 8'(st.quiet_count + 8'd1) : st.quiet_count;
    rate_mag  = s1_item.rate_sample[15] ? 16'(~s1_item.rate_sample + 16'sd1)
                                        : 16'(s1_item.rate_sample);
    hold_elapsed = s1_item.now_ms - st.phase_one_start;
    elapsed      = s1_item.now_ms - st.phase_two_start;

    abort_now             = st.abort_latched || s1_item.abort_request;
    st_next.abort_latched = abort_now;

    if (s1_item.command == CMD_START) begin
      if (!abort_now) begin
        st_next.running         = 1'b1;
        st_next.phase_two       = 1'b0;
        st_next.phase_one_start = s1_item.now_ms;
        st_next.phase_two_start = '0;
        st_next.hold_time       = s1_item.hold_ms;
        st_next.second_voltage  = s1_item.to_mv;
        st_next.drive_level     = s1_item.from_mv;
        st_next.tick_count      = '0;
        st_next.stored_count    = '0;
        st_next.quiet_count     = '0;
      end else begin
        if (st.running) begin
          done          = 1'b1;
          res.end_cause = STOP_ABORTED;
          phase_out     = st.phase_two;
        end
        st_next.running     = 1'b0;
        st_next.phase_two   = 1'b0;
        st_next.drive_level = '0;
      end
    end else if (st.running) begin
      if (abort_now) begin
        done          = 1'b1;
        res.end_cause = STOP_ABORTED;
      end else begin
        // hold expiry steps to the second voltage, elapsed starts at zero
        if (!st.phase_two && (hold_elapsed >= {12'd0, st.hold_time})) begin
          st_next.drive_level     = st.second_voltage;
          st_next.phase_two       = 1'b1;
          st_next.phase_two_start = s1_item.now_ms;
          elapsed                 = '0;
        end
        st_next.tick_count = tick_inc;
        log_tick           = (tick_inc >= cfg.decimation);
        if (log_tick) begin
          st_next.tick_count = '0;
          if (st.stored_count >= cfg.max_samples) begin
            done          = 1'b1;
            res.end_cause = STOP_BUFFER_FULL;
          end else begin
            res.log_strobe       = 1'b1;
            res.sample_index     = st.stored_count;
            st_next.stored_count = 16'(st.stored_count + 16'd1);
            if (st_next.phase_two) begin
              if (elapsed >= {12'd0, cfg.settle_delay_ms}) begin
                if (rate_mag < {1'b0, cfg.settle_threshold}) begin
                  st_next.quiet_count = quiet_inc;
                  if (quiet_inc >= cfg.settle_needed) begin
                    done          = 1'b1;
                    res.end_cause = STOP_SETTLED;
                  end
                end else begin
                  st_next.quiet_count = '0;
                end
              end
              // settle wins over timeout on the same sample
              if (!done && (elapsed >= {12'd0, cfg.timeout_ms})) begin
                done          = 1'b1;
                res.end_cause = STOP_TIMEOUT;
              end
            end
          end
        end
      end
      phase_out = st_next.phase_two;
      if (done) begin
        st_next.running     = 1'b0;
        st_next.phase_two   = 1'b0;
        st_next.drive_level = '0;
      end
    end else begin
      st_next.drive_level = '0;
      st_next.phase_two   = 1'b0;
    end

    if (st_next.running) begin
      phase_out = st_next.phase_two;
    end

    res.drive_mv     = st_next.drive_level;
    res.in_phase_b   = phase_out;
    res.capture_done = done;
  end

endmodule

// ----- design/step_test_capture_sequencer.sv -----
// top level of the step test capture sequencer
// depends on stcs_pkg, stcs_item_if, stcs_result_if, stcs_cfg_regs and stcs_engine

// The block takes one transaction per clock on the item channel unless the
// result sink stalls, and returns exactly one result transaction for each,
// in order. A start item (command 0) loads the from voltage, the to voltage
// and the hold time; each tick item (command 1) advances the capture: phase
// one drive until the hold has passed, then the step to the second voltage,
// a log strobe every decimation-th tick, and the end of capture on buffer
// full, debounced settle, timeout or abort. Throughput is one item per cycle
// unless the sink stalls: an input register, then the whole step (a few
// 32-bit subtract/compares and counter updates) in one pass that writes
// both the sequencer state and the result register. The state loop closes
// within that pass, so consecutive items never wait on each other. The
// result register holds a finished result while the sink stalls and the
// input register still takes one more item. Configuration lives in six
// 32-bit registers at byte addresses 0, 4, ... 20 and must only be written
// while the block is idle. No clearing pass is needed after reset.

module step_test_capture_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  stcs_item_if.sink                   item,
  stcs_result_if.source               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stcs_pkg::ADDR_W-1:0] paddr,
  input  logic [stcs_pkg::DATA_W-1:0] pwdata,
  output logic [stcs_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import stcs_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  result_t out_res;

  // register file; the user must write it only between captures, the block does not enforce this
  stcs_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // pack the item channel fields
  assign in_item.command       = item.command;
  assign in_item.now_ms        = item.now_ms;
  assign in_item.from_mv       = item.from_mv;
  assign in_item.to_mv         = item.to_mv;
  assign in_item.hold_ms       = item.hold_ms;
  assign in_item.rate_sample   = item.rate_sample;
  assign in_item.abort_request = item.abort_request;

  // sequencer state and step logic
  stcs_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_item   (in_item),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_res   (out_res)
  );

  // unpack the result register onto the result channel
  assign result.drive_mv     = out_res.drive_mv;
  assign result.log_strobe   = out_res.log_strobe;
  assign result.sample_index = out_res.sample_index;
  assign result.in_phase_b   = out_res.in_phase_b;
  assign result.capture_done = out_res.capture_done;
  assign result.end_cause    = 2'(out_res.end_cause);

endmodule

// ----- design/stcs_checker.sv -----
// port-level checks on the result channel of the sequencer
// depends on stcs_pkg; bound to step_test_capture_sequencer

module stcs_checker (
  input logic               clk,
  input logic               rst,
  input logic               valid,
  input logic               ready,
  input logic signed [14:0] drive_mv,
  input logic               log_strobe,
  input logic [15:0]        sample_index,
  input logic               capture_done,
  input logic [1:0]         end_cause
);
  import stcs_pkg::*;

  // a reason is only reported on the transaction that ends a capture
  a_reason_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (valid && !capture_done) |-> (end_cause == 2'(STOP_SETTLED)))
    else $error("end cause set without capture done");

  // the sample index is zero unless a sample is stored
  a_index_only_on_strobe: assert property (@(posedge clk) disable iff (rst)
    (valid && !log_strobe) |-> (sample_index == 16'd0))
    else $error("sample index set without log strobe");

  // ending a capture always releases the drive
  a_done_zero_drive: assert property (@(posedge clk) disable iff (rst)
    (valid && capture_done) |-> (drive_mv == 15'sd0))
    else $error("drive not zero at end of capture");

  // a stalled result holds its payload
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (valid && !ready) |=>
      (valid && $stable(drive_mv) && $stable(sample_index) &&
       $stable(capture_done) && $stable(end_cause)))
    else $error("result changed while stalled");

endmodule

bind step_test_capture_sequencer stcs_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .valid        (result.valid),
  .ready        (result.ready),
  .drive_mv     (result.drive_mv),
  .log_strobe   (result.log_strobe),
  .sample_index (result.sample_index),
  .capture_done (result.capture_done),
  .end_cause    (result.end_cause)
);
